@@ rtl/bfd_pkg.sv @@
// Package with the constants, payload types and status codes of the fraction-to-decimal core.
package bfd_pkg;

  localparam int FRAC_BITS = 128;
  localparam int MANT_W = 64;
  localparam int EXP_W = 16;
  localparam int DIGITS_PER_BEAT = 8;
  localparam int MAX_BEATS = 16;
  localparam int NUM_BEATS_RAW = (FRAC_BITS + DIGITS_PER_BEAT - 1) / DIGITS_PER_BEAT;
  localparam int NUM_BEATS = (NUM_BEATS_RAW > MAX_BEATS) ? MAX_BEATS : NUM_BEATS_RAW;
  localparam int BEAT_W = (NUM_BEATS > 1) ? $clog2(NUM_BEATS) : 1;
  localparam int STEP_W = $clog2(FRAC_BITS + 1);
  localparam int PAD_BITS = FRAC_BITS - MANT_W;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic [1:0] {
    STATUS_DIGITS   = 2'd0,
    STATUS_NO_FRAC  = 2'd1,
    STATUS_RANGE    = 2'd2,
    STATUS_RESERVED = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [EXP_W-1:0] exponent;
    logic [MANT_W-1:0]       mantissa;
  } in_t;

  typedef struct packed {
    logic [63:0] text_chars;
    status_e     status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
  } feed_ctrl_t;

  typedef struct packed {
    logic clear;
    logic halve;
    logic advance;
  } bcd_ctrl_t;

endpackage

@@ rtl/bfd_feed.sv @@
// Serial feeder that delivers the binary fraction one bit per cycle while stepped, last fraction bit first.
module bfd_feed
  import bfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  feed_ctrl_t        ctrl_i,
  input  logic [STEP_W-1:0] pad_i,
  input  logic [MANT_W-1:0] mantissa_i,
  output logic              bit_o
);

  logic [MANT_W-1:0] mant_q, mant_d;
  logic [STEP_W-1:0] pad_q, pad_d;

  always_comb begin
    mant_d = mant_q;
    pad_d  = pad_q;
    if (ctrl_i.load) begin
      mant_d = mantissa_i;
      pad_d  = pad_i;
    end else if (ctrl_i.step) begin
      if (pad_q != '0) begin
        pad_d = pad_q - STEP_W'(1);
      end else begin
        mant_d = {1'b0, mant_q[MANT_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= '0;
    end else begin
      pad_q <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q <= mant_d;
  end

  assign bit_o = (pad_q == '0) & mant_q[0];

endmodule

@@ rtl/bfd_bcd.sv @@
// BCD digit register that adds the input bit and halves per step, giving eight digits per beat.
module bfd_bcd
  import bfd_pkg::*;
(
  input  logic        clk_i,
  input  bcd_ctrl_t   ctrl_i,
  input  logic        bit_i,
  output logic [63:0] text_o
);

  logic [3:0] bcd_q [FRAC_BITS];
  logic [3:0] bcd_d [FRAC_BITS];
  logic [3:0] halved [FRAC_BITS];

  always_comb begin
    logic [3:0] shifted;
    logic       carry;
    for (int i = 0; i < FRAC_BITS; i++) begin
      carry = (i == 0) ? bit_i : bcd_q[(i == 0) ? 0 : i - 1][0];
      shifted = {carry, bcd_q[i][3:1]};
      halved[i] = (shifted > 4'd7) ? shifted - 4'd3 : shifted;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAC_BITS; i++) begin
      bcd_d[i] = bcd_q[i];
      if (ctrl_i.clear) begin
        bcd_d[i] = '0;
      end else if (ctrl_i.halve) begin
        bcd_d[i] = halved[i];
      end else if (ctrl_i.advance) begin
        if (i < FRAC_BITS - DIGITS_PER_BEAT) begin
          bcd_d[i] = bcd_q[(i < FRAC_BITS - DIGITS_PER_BEAT) ? i + DIGITS_PER_BEAT : i];
        end else begin
          bcd_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAC_BITS; i++) begin
      bcd_q[i] <= bcd_d[i];
    end
  end

  always_comb begin
    for (int j = 0; j < DIGITS_PER_BEAT; j++) begin
      text_o[63 - 8 * j -: 8] = {4'h0, bcd_q[j]} + ASCII_ZERO;
    end
  end

endmodule

@@ rtl/binary_fraction_to_decimal_core.sv @@
// Top level of the binary fraction to decimal converter with control and output register.
//
// Input channel in_valid_i / in_ready_o carries one exponent and mantissa per
// transfer. The mantissa top bit has weight two to the power of the exponent.
// Output channel out_valid_o / out_ready_i carries eight ASCII digits per
// transfer, first digit in the top byte; the final transfer of a conversion
// has last set.
// A negative exponent whose mantissa fits the 128-bit fraction yields sixteen
// transfers of digits. A non-negative exponent yields one transfer with the
// no-fraction status, and a mantissa reaching past the fraction yields one
// transfer with the out-of-range status.
// A conversion feeds the fraction into the BCD register one bit per cycle,
// then loads one output beat per cycle while the receiver takes them.
// A status-only item passes from the emit state into the output register.
// A new item is taken once the last beat of the previous one sits in the
// output register. A stalled receiver holds the output register and halts
// the beat sequence. Reset empties the output register and returns the
// control to idle.
module binary_fraction_to_decimal_core
  import bfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [BEAT_W-1:0] beat_q, beat_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  feed_ctrl_t        feed_ctrl;
  bcd_ctrl_t         bcd_ctrl;
  logic              feed_bit;
  logic [63:0]       text;
  logic [EXP_W-2:0]  lead_zeros;
  logic              out_of_range;
  logic [STEP_W-1:0] pad;
  logic              accept;
  logic              out_free;
  logic              beat_last;

  assign lead_zeros   = ~in_i.exponent[EXP_W-2:0];
  assign out_of_range = {1'b0, lead_zeros} > EXP_W'(PAD_BITS);
  assign pad          = STEP_W'(PAD_BITS) - lead_zeros[STEP_W-1:0];
  assign accept       = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign beat_last    = (status_q != STATUS_DIGITS) || (beat_q == BEAT_W'(NUM_BEATS - 1));

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    beat_d      = beat_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    feed_ctrl   = '0;
    bcd_ctrl    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          beat_d = '0;
          if (!in_i.exponent[EXP_W-1]) begin
            status_d = STATUS_NO_FRAC;
            state_d  = ST_EMIT;
          end else if (out_of_range) begin
            status_d = STATUS_RANGE;
            state_d  = ST_EMIT;
          end else begin
            status_d       = STATUS_DIGITS;
            step_d         = '0;
            feed_ctrl.load = 1'b1;
            bcd_ctrl.clear = 1'b1;
            state_d        = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        feed_ctrl.step = 1'b1;
        bcd_ctrl.halve = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(FRAC_BITS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.text_chars = (status_q == STATUS_DIGITS) ? text : '0;
          out_d.status     = status_q;
          out_d.last       = beat_last;
          bcd_ctrl.advance = 1'b1;
          beat_d           = beat_q + BEAT_W'(1);
          if (beat_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      beat_q      <= '0;
      status_q    <= STATUS_DIGITS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      beat_q      <= beat_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  bfd_feed u_feed (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (feed_ctrl),
    .pad_i      (pad),
    .mantissa_i (in_i.mantissa),
    .bit_o      (feed_bit)
  );

  bfd_bcd u_bcd (
    .clk_i  (clk_i),
    .ctrl_i (bcd_ctrl),
    .bit_i  (feed_bit),
    .text_o (text)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_shift_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) && (step_q == STEP_W'(FRAC_BITS - 1))
    |=> (state_q == ST_EMIT) && (beat_q == '0))
    else $error("shift phase did not hand over to the first output beat");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != STATUS_DIGITS) |-> out_o.last)
    else $error("status result not marked last");

  a_status_no_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != STATUS_DIGITS) |-> (out_o.text_chars == '0))
    else $error("status result carries digits");

  a_no_frac_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_i.exponent[EXP_W-1]
    |=> (state_q == ST_EMIT) && (status_q == STATUS_NO_FRAC))
    else $error("non-negative exponent not routed to no-fraction status");
`endif

endmodule
